/* hw/rtl/ffra_pkg.sv */
// shared types and constants of the first-fit region allocator
package ffra_pkg;

   // command codes
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_LOOKUP  = 2'd2;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam int CMD_W    = 2;
   localparam int SIZE_W   = 17;
   localparam int ADDR_W   = 16;
   localparam int GAPCNT_W = 5;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_DEC   = 7'b0000100,
      ST_SHIFT = 7'b0001000,
      ST_STATS = 7'b0010000,
      ST_LAST  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   // one result item
   typedef struct packed {
      logic                status;
      logic [ADDR_W-1:0]   alloc_offset;
      logic [SIZE_W-1:0]   extent_length;
      logic [SIZE_W-1:0]   used_bytes;
      logic [GAPCNT_W-1:0] gap_count;
      logic [SIZE_W-1:0]   free_total;
      logic [SIZE_W-1:0]   largest_gap;
   } rsp_type;

endpackage

/* hw/rtl/ffra_req_if.sv */
// request channel interface
interface ffra_req_if;
   logic                          valid;
   logic                          ready;
   logic [ffra_pkg::CMD_W-1:0]    cmd;
   logic [ffra_pkg::SIZE_W-1:0]   request_size;
   logic [ffra_pkg::ADDR_W-1:0]   address;

   modport source (output valid, cmd, request_size, address, input ready);
   modport sink   (input valid, cmd, request_size, address, output ready);
endinterface

/* hw/rtl/ffra_rsp_if.sv */
// response channel interface
interface ffra_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [ffra_pkg::ADDR_W-1:0]    alloc_offset;
   logic [ffra_pkg::SIZE_W-1:0]    extent_length;
   logic [ffra_pkg::SIZE_W-1:0]    used_bytes;
   logic [ffra_pkg::GAPCNT_W-1:0]  gap_count;
   logic [ffra_pkg::SIZE_W-1:0]    free_total;
   logic [ffra_pkg::SIZE_W-1:0]    largest_gap;

   modport source (output valid, status, alloc_offset, extent_length, used_bytes,
                   gap_count, free_total, largest_gap, input ready);
   modport sink   (input valid, status, alloc_offset, extent_length, used_bytes,
                   gap_count, free_total, largest_gap, output ready);
endinterface

/* hw/rtl/first_fit_region_allocator.sv */
// First-fit region allocator. A sorted table of up to MAX_EXTENTS extents lives in a
// single-port-read synchronous memory, walked one entry per cycle by a sequencer. From
// acceptance to a valid result, an item takes these steps in order: one pass to find
// the gap or the extent, then a shift of the table entries that lie above it
// on insert or removal (the find and shift passes together cover the table about once),
// and one pass to gather used bytes, gap count, free total and largest gap; the single
// memory read port makes the passes serial. A new item is taken only once the previous
// result is accepted from the output register, in the cycle after that handshake.
module first_fit_region_allocator #(
   parameter int MAX_EXTENTS = 16
) (
   input  logic clock,
   input  logic reset,
   ffra_req_if.sink   req,
   ffra_rsp_if.source rsp,
   input  logic                        csr_we,
   input  logic [ffra_pkg::SIZE_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int SW    = ffra_pkg::SIZE_W;
   localparam int AW    = ffra_pkg::ADDR_W;

   ffra_pkg::state_type state_ff, state_in;

   logic [SW-1:0]    region_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             rdv_ff, rdv_in;
   logic             found_ff, found_in;
   logic [SW-1:0]    prev_end_ff, prev_end_in;
   logic [1:0]       cmd_ff;
   logic [SW-1:0]    size_ff;
   logic [AW-1:0]    addr_ff;
   logic [SW-1:0]    len_ff, len_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [SW-1:0]    used_ff, used_in;
   logic [ffra_pkg::GAPCNT_W-1:0] gaps_ff, gaps_in;
   logic [SW-1:0]    ftot_ff, ftot_in;
   logic [SW-1:0]    big_ff, big_in;
   logic             ok_ff, ok_in;
   logic             out_valid_ff;
   ffra_pkg::rsp_type out_ff, out_in;
   logic             req_take, out_load;

   // memory ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic [AW-1:0]    wr_start, rd_start;
   logic [SW-1:0]    wr_len, rd_len;
   logic [CNT_W-1:0] rd_sel;

   ffra_table #(.DEPTH(MAX_EXTENTS), .IDX_W(IDX_W)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_idx(wr_idx), .wr_start(wr_start), .wr_len(wr_len),
      .rd_idx(rd_idx), .rd_start(rd_start), .rd_len(rd_len)
   );
   assign rd_idx = rd_sel[IDX_W-1:0];

   // effective region and helper values
   logic [SW-1:0] eff_region, rd_end, gap, tail_gap;
   logic [SW-1:0] rd_start_w;
   assign eff_region = (region_ff > SW'(65536)) ? SW'(65536) : region_ff;
   assign rd_start_w = SW'(rd_start);
   assign rd_end     = rd_start_w + rd_len;
   assign gap        = (rd_start_w > prev_end_ff) ? rd_start_w - prev_end_ff : '0;
   assign tail_gap   = (eff_region > prev_end_ff) ? eff_region - prev_end_ff : '0;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= SW'(65536);
      end else if (csr_we) begin
         region_ff <= csr_wdata;
      end
   end

   assign req.ready = state_ff[0] && !out_valid_ff;
   assign req_take  = req.valid && req.ready;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      rdv_in      = 1'b0;
      found_in    = found_ff;
      prev_end_in = prev_end_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      used_in     = used_ff;
      gaps_in     = gaps_ff;
      ftot_in     = ftot_ff;
      big_in      = big_ff;
      ok_in       = ok_ff;
      rd_sel      = i_ff;
      wr_en       = 1'b0;
      wr_idx      = k_ff[IDX_W-1:0];
      wr_start    = pos_ff;
      wr_len      = len_ff;
      out_load    = 1'b0;
      out_in      = out_ff;
      unique case (state_ff)
         ffra_pkg::ST_IDLE: begin
            rd_sel = '0;
            if (req_take) begin
               i_in        = '0;
               rdv_in      = 1'b0;
               found_in    = 1'b0;
               prev_end_in = '0;
               len_in      = '0;
               pos_in      = '0;
               ok_in       = 1'b0;
               state_in    = ffra_pkg::ST_SCAN;
            end
         end
         // walk entries to find the gap or the extent
         ffra_pkg::ST_SCAN: begin
            rd_sel = i_ff + CNT_W'(1);
            if (!rdv_ff) begin
               rd_sel = i_ff;
               rdv_in = (i_ff < count_ff);
               if (i_ff >= count_ff) begin
                  // past the last extent: trailing gap for allocate
                  if (cmd_ff == ffra_pkg::CMD_ALLOC && !found_ff && tail_gap >= size_ff
                      && size_ff != '0 && size_ff <= eff_region
                      && count_ff < CNT_W'(MAX_EXTENTS)) begin
                     found_in = 1'b1;
                     k_in     = i_ff;
                     pos_in   = prev_end_ff[AW-1:0];
                  end
                  state_in = ffra_pkg::ST_DEC;
               end
            end else begin
               rdv_in = (i_ff + CNT_W'(1) < count_ff);
               i_in   = i_ff + CNT_W'(1);
               if (cmd_ff == ffra_pkg::CMD_ALLOC) begin
                  if (gap >= size_ff && size_ff != '0 && size_ff <= eff_region
                      && count_ff < CNT_W'(MAX_EXTENTS)) begin
                     found_in = 1'b1;
                     k_in     = i_ff;
                     pos_in   = prev_end_ff[AW-1:0];
                     rdv_in   = 1'b0;
                     state_in = ffra_pkg::ST_DEC;
                  end
               end else if (rd_start_w <= SW'(addr_ff) && SW'(addr_ff) < rd_end) begin
                  found_in = 1'b1;
                  k_in     = i_ff;
                  len_in   = rd_len;
                  rdv_in   = 1'b0;
                  state_in = ffra_pkg::ST_DEC;
               end
               prev_end_in = rd_end;
               if (!rdv_in && state_in == ffra_pkg::ST_SCAN) begin
                  // next cycle handles the trailing gap
               end
            end
         end
         // decide what shift is needed
         ffra_pkg::ST_DEC: begin
            ok_in = found_ff && (cmd_ff == ffra_pkg::CMD_ALLOC
                                 || cmd_ff == ffra_pkg::CMD_FREE
                                 || cmd_ff == ffra_pkg::CMD_LOOKUP);
            if (found_ff && cmd_ff == ffra_pkg::CMD_ALLOC) begin
               // move entries count-1 .. k up by one, from the top
               i_in     = count_ff;
               rd_sel   = count_ff - CNT_W'(1);
               rdv_in   = (count_ff > k_ff);
               state_in = ffra_pkg::ST_SHIFT;
            end else if (found_ff && cmd_ff == ffra_pkg::CMD_FREE) begin
               i_in     = k_ff;
               rd_sel   = k_ff + CNT_W'(1);
               rdv_in   = (k_ff + CNT_W'(1) < count_ff);
               state_in = ffra_pkg::ST_SHIFT;
            end else begin
               i_in     = '0;
               rd_sel   = '0;
               rdv_in   = (count_ff != '0);
               prev_end_in = '0;
               used_in  = '0;
               gaps_in  = '0;
               ftot_in  = '0;
               big_in   = '0;
               state_in = ffra_pkg::ST_STATS;
            end
         end
         // shift entries one place, one per cycle
         ffra_pkg::ST_SHIFT: begin
            if (cmd_ff == ffra_pkg::CMD_ALLOC) begin
               if (rdv_ff) begin
                  wr_en    = 1'b1;
                  wr_idx   = i_ff[IDX_W-1:0];
                  wr_start = rd_start;
                  wr_len   = rd_len;
                  i_in     = i_ff - CNT_W'(1);
                  rd_sel   = i_ff - CNT_W'(2);
                  rdv_in   = (i_ff - CNT_W'(1) > k_ff);
               end else begin
                  wr_en    = 1'b1;
                  wr_idx   = k_ff[IDX_W-1:0];
                  wr_start = pos_ff;
                  wr_len   = size_ff;
                  count_in = count_ff + CNT_W'(1);
                  i_in     = '0;
                  rd_sel   = '0;
                  rdv_in   = 1'b1;
                  prev_end_in = '0;
                  used_in  = '0;
                  gaps_in  = '0;
                  ftot_in  = '0;
                  big_in   = '0;
                  state_in = ffra_pkg::ST_STATS;
               end
            end else begin
               if (rdv_ff) begin
                  wr_en    = 1'b1;
                  wr_idx   = i_ff[IDX_W-1:0];
                  wr_start = rd_start;
                  wr_len   = rd_len;
                  i_in     = i_ff + CNT_W'(1);
                  rd_sel   = i_ff + CNT_W'(2);
                  rdv_in   = (i_ff + CNT_W'(2) < count_ff);
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  i_in     = '0;
                  rd_sel   = '0;
                  rdv_in   = (count_ff > CNT_W'(1));
                  prev_end_in = '0;
                  used_in  = '0;
                  gaps_in  = '0;
                  ftot_in  = '0;
                  big_in   = '0;
                  state_in = ffra_pkg::ST_STATS;
               end
            end
         end
         // gather statistics over the table
         ffra_pkg::ST_STATS: begin
            rd_sel = i_ff + CNT_W'(1);
            if (rdv_ff) begin
               used_in     = used_ff + rd_len;
               prev_end_in = rd_end;
               if (gap != '0) begin
                  gaps_in = gaps_ff + ffra_pkg::GAPCNT_W'(1);
                  ftot_in = ftot_ff + gap;
                  if (gap > big_ff) big_in = gap;
               end
               i_in   = i_ff + CNT_W'(1);
               rdv_in = (i_ff + CNT_W'(1) < count_ff);
               if (!rdv_in) state_in = ffra_pkg::ST_LAST;
            end else begin
               state_in = ffra_pkg::ST_LAST;
            end
         end
         // trailing gap
         ffra_pkg::ST_LAST: begin
            if (tail_gap != '0) begin
               gaps_in = gaps_ff + ffra_pkg::GAPCNT_W'(1);
               ftot_in = ftot_ff + tail_gap;
               if (tail_gap > big_ff) big_in = tail_gap;
            end
            state_in = ffra_pkg::ST_OUT;
         end
         ffra_pkg::ST_OUT: begin
            out_load             = 1'b1;
            out_in.status        = !ok_ff;
            out_in.alloc_offset  = (ok_ff && cmd_ff == ffra_pkg::CMD_ALLOC) ? pos_ff : '0;
            out_in.extent_length = (ok_ff && cmd_ff != ffra_pkg::CMD_ALLOC) ? len_ff : '0;
            out_in.used_bytes    = used_ff;
            out_in.gap_count     = gaps_ff;
            out_in.free_total    = ftot_ff;
            out_in.largest_gap   = big_ff;
            state_in             = ffra_pkg::ST_IDLE;
         end
         default: state_in = ffra_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffra_pkg::ST_IDLE;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff   <= rdv_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      k_ff        <= k_in;
      found_ff    <= found_in;
      prev_end_ff <= prev_end_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      used_ff     <= used_in;
      gaps_ff     <= gaps_in;
      ftot_ff     <= ftot_in;
      big_ff      <= big_in;
      ok_ff       <= ok_in;
      out_ff      <= out_in;
      if (req_take) begin
         cmd_ff  <= req.cmd;
         size_ff <= req.request_size;
         addr_ff <= req.address;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.status        = out_ff.status;
   assign rsp.alloc_offset  = out_ff.alloc_offset;
   assign rsp.extent_length = out_ff.extent_length;
   assign rsp.used_bytes    = out_ff.used_bytes;
   assign rsp.gap_count     = out_ff.gap_count;
   assign rsp.free_total    = out_ff.free_total;
   assign rsp.largest_gap   = out_ff.largest_gap;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EXTENTS)) else $error("extent count overflow");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready) else $error("item taken while busy");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(state_ff == ffra_pkg::ST_SHIFT))
      else $error("count changed outside shift");

endmodule

/* hw/rtl/ffra_table.sv */
// extent table memory: start and length per entry, one write and one read port
module ffra_table #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [ffra_pkg::ADDR_W-1:0]   wr_start,
   input  logic [ffra_pkg::SIZE_W-1:0]   wr_len,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic [ffra_pkg::ADDR_W-1:0]   rd_start,
   output logic [ffra_pkg::SIZE_W-1:0]   rd_len
);

   logic [ffra_pkg::ADDR_W+ffra_pkg::SIZE_W-1:0] mem_ff [DEPTH];
   logic [ffra_pkg::ADDR_W+ffra_pkg::SIZE_W-1:0] rd_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= {wr_start, wr_len};
      end
   end

   // registered read port, a write to the same entry is passed through
   always_ff @(posedge clock) begin
      if (wr_en && wr_idx == rd_idx) begin
         rd_ff <= {wr_start, wr_len};
      end else begin
         rd_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_start = rd_ff[ffra_pkg::ADDR_W+ffra_pkg::SIZE_W-1:ffra_pkg::SIZE_W];
   assign rd_len   = rd_ff[ffra_pkg::SIZE_W-1:0];

endmodule

/* sim/tb.sv */
// testbench for the first-fit region allocator: predictor, driver, monitor and checker
`timescale 1ns / 100ps

module tb;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [ffra_pkg::CMD_W-1:0]  cmd;
      logic [ffra_pkg::SIZE_W-1:0] request_size;
      logic [ffra_pkg::ADDR_W-1:0] address;
   } alloc_cmd_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ffra_pkg::SIZE_W-1:0] csr_wdata;

   ffra_req_if req_ch ();
   ffra_rsp_if rsp_ch ();

   first_fit_region_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   int unsigned tbl_start [TABLE_DEPTH];
   int unsigned tbl_len [TABLE_DEPTH];
   int unsigned tbl_count;
   int unsigned region_bytes;

   alloc_cmd_type     pending_cmds[$];
   ffra_pkg::rsp_type expected_rsps[$];
   int         fail_count;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         hold_cycles;
   int unsigned cycle_count;
   int unsigned sent_count;
   logic        req_done;

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int unsigned gap_of(int unsigned g);
      int unsigned lo;
      int unsigned hi;
      lo = (g == 0) ? 0 : tbl_start[g-1] + tbl_len[g-1];
      hi = (g < tbl_count) ? tbl_start[g] : region_bytes;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   // work out the result of one command and update the table
   function automatic ffra_pkg::rsp_type predict_alloc(alloc_cmd_type c);
      ffra_pkg::rsp_type r;
      int unsigned g;
      int unsigned k;
      int unsigned s;
      int unsigned pos;
      int unsigned used;
      int unsigned gaps;
      int unsigned ftot;
      int unsigned big;
      r = '0;
      r.status = 1'b1;
      used = 0; gaps = 0; ftot = 0; big = 0;
      if (c.cmd == ffra_pkg::CMD_ALLOC) begin
         if (c.request_size >= 1 && c.request_size <= region_bytes &&
             tbl_count < TABLE_DEPTH) begin
            for (g = 0; g <= tbl_count; g++)
               if (gap_of(g) >= c.request_size) break;
            if (g <= tbl_count) begin
               pos = (g == 0) ? 0 : tbl_start[g-1] + tbl_len[g-1];
               for (k = tbl_count; k > g; k--) begin
                  tbl_start[k] = tbl_start[k-1];
                  tbl_len[k] = tbl_len[k-1];
               end
               tbl_start[g] = pos;
               tbl_len[g] = c.request_size;
               tbl_count++;
               r.status = 1'b0;
               r.alloc_offset = pos[ffra_pkg::ADDR_W-1:0];
            end
         end
      end else if (c.cmd == ffra_pkg::CMD_FREE || c.cmd == ffra_pkg::CMD_LOOKUP) begin
         for (k = 0; k < tbl_count; k++)
            if (tbl_start[k] <= c.address && c.address < tbl_start[k] + tbl_len[k]) break;
         if (k < tbl_count) begin
            r.status = 1'b0;
            r.extent_length = tbl_len[k][ffra_pkg::SIZE_W-1:0];
            if (c.cmd == ffra_pkg::CMD_FREE) begin
               for (; k + 1 < tbl_count; k++) begin
                  tbl_start[k] = tbl_start[k+1];
                  tbl_len[k] = tbl_len[k+1];
               end
               tbl_count--;
            end
         end
      end
      for (k = 0; k < tbl_count; k++) used += tbl_len[k];
      for (g = 0; g <= tbl_count; g++) begin
         s = gap_of(g);
         if (s > 0) begin
            gaps++;
            ftot += s;
            if (s > big) big = s;
         end
      end
      r.used_bytes = used[ffra_pkg::SIZE_W-1:0];
      r.gap_count = gaps[ffra_pkg::GAPCNT_W-1:0];
      r.free_total = ftot[ffra_pkg::SIZE_W-1:0];
      r.largest_gap = big[ffra_pkg::SIZE_W-1:0];
      return r;
   endfunction

   // input sampler: predicts each item at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_rsps.push_back(predict_alloc({req_ch.cmd, req_ch.request_size,
                                                req_ch.address}));
         sent_count++;
         req_done <= 1'b1;
      end else begin
         req_done <= 1'b0;
      end
   end

   // driver: offers queued commands, holds each until it is accepted
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_done) begin
         if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_ch.valid        <= 1'b1;
            req_ch.cmd          <= pending_cmds[0].cmd;
            req_ch.request_size <= pending_cmds[0].request_size;
            req_ch.address      <= pending_cmds[0].address;
            void'(pending_cmds.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with a long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles  <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      ffra_pkg::rsp_type got;
      ffra_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.status, rsp_ch.alloc_offset, rsp_ch.extent_length, rsp_ch.used_bytes,
                rsp_ch.gap_count, rsp_ch.free_total, rsp_ch.largest_gap};
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected item %h", $time, got);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
               $display("%0t status exp %0d got %0d", $time, want.status, got.status);
            if (got.alloc_offset !== want.alloc_offset)
               $display("%0t alloc_offset exp %0d got %0d", $time,
                        want.alloc_offset, got.alloc_offset);
            if (got.extent_length !== want.extent_length)
               $display("%0t extent_length exp %0d got %0d", $time,
                        want.extent_length, got.extent_length);
            if (got.used_bytes !== want.used_bytes)
               $display("%0t used_bytes exp %0d got %0d", $time,
                        want.used_bytes, got.used_bytes);
            if (got.gap_count !== want.gap_count)
               $display("%0t gap_count exp %0d got %0d", $time,
                        want.gap_count, got.gap_count);
            if (got.free_total !== want.free_total)
               $display("%0t free_total exp %0d got %0d", $time,
                        want.free_total, got.free_total);
            if (got.largest_gap !== want.largest_gap)
               $display("%0t largest_gap exp %0d got %0d", $time,
                        want.largest_gap, got.largest_gap);
            if (got !== want) fail_count++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_cmd(logic [ffra_pkg::CMD_W-1:0] c, int unsigned sz, int unsigned a);
      alloc_cmd_type x;
      x.cmd = c;
      x.request_size = sz[ffra_pkg::SIZE_W-1:0];
      x.address = a[ffra_pkg::ADDR_W-1:0];
      pending_cmds.push_back(x);
   endtask

   task automatic drain_all();
      while (pending_cmds.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // write the region size while idle
   task automatic set_region(int unsigned sz);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= sz[ffra_pkg::SIZE_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      region_bytes = (sz > 65536) ? 65536 : sz;
   endtask

   // random traffic: allocations, frees and lookups at random addresses, and a few unknown commands
   task automatic add_random(int n);
      int unsigned pick;
      int unsigned sz;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99, 0);
         case ($urandom_range(3, 0))
            0: sz = $urandom_range(64, 1);
            1: sz = $urandom_range(4096, 1);
            2: sz = $urandom_range(65536, 0);
            default: sz = $urandom_range(region_bytes / 4 + 1, 1);
         endcase
         if (pick < 45)
            add_cmd(ffra_pkg::CMD_ALLOC, sz, $urandom_range(65535, 0));
         else if (pick < 70)
            add_cmd(ffra_pkg::CMD_FREE, $urandom_range(131071, 0),
                    (i % 2) ? $urandom_range(65535, 0) : $urandom_range(region_bytes, 0));
         else if (pick < 95)
            add_cmd(ffra_pkg::CMD_LOOKUP, $urandom_range(131071, 0),
                    (i % 2) ? $urandom_range(65535, 0) : $urandom_range(region_bytes, 0));
         else
            add_cmd(ffra_pkg::CMD_UNKNOWN, $urandom_range(131071, 0),
                    $urandom_range(65535, 0));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.request_size = '0;
      req_ch.address = '0;
      rsp_ch.ready = 1'b0;
      req_done = 1'b0;
      fail_count = 0;
      hold_cycles = 0;
      cycle_count = 0;
      sent_count = 0;
      tbl_count = 0;
      region_bytes = 65536;
      send_idle_pct = 6;
      recv_idle_pct = 50;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, table full, no fit, unknown command
      add_cmd(ffra_pkg::CMD_LOOKUP, 0, 0);
      add_cmd(ffra_pkg::CMD_ALLOC, 0, 0);
      add_cmd(ffra_pkg::CMD_ALLOC, 65536, 65535);
      add_cmd(ffra_pkg::CMD_LOOKUP, 0, 65535);
      add_cmd(ffra_pkg::CMD_FREE, 0, 0);
      add_cmd(ffra_pkg::CMD_ALLOC, 131071, 0);
      add_cmd(ffra_pkg::CMD_UNKNOWN, 131071, 65535);
      for (int i = 0; i < 17; i++) add_cmd(ffra_pkg::CMD_ALLOC, 100, 0);
      add_cmd(ffra_pkg::CMD_FREE, 0, 250);
      add_cmd(ffra_pkg::CMD_ALLOC, 200, 0);
      add_cmd(ffra_pkg::CMD_ALLOC, 60000, 0);
      drain_all();

      // shrink region below extents, then extremes of the register
      set_region(1000);
      add_cmd(ffra_pkg::CMD_LOOKUP, 0, 1550);
      add_cmd(ffra_pkg::CMD_ALLOC, 1, 0);
      add_random(300);
      drain_all();
      set_region(1);
      add_random(100);
      drain_all();

      // long receiver hold-off so the input stalls
      set_region(131071);
      hold_cycles = 2000;
      add_random(150);
      drain_all();
      for (int i = 0; i < 16; i++) add_cmd(ffra_pkg::CMD_FREE, 0, i * 4096);
      drain_all();

      send_idle_pct = 50;
      recv_idle_pct = 6;
      set_region(65535);
      add_random(300);
      drain_all();
      set_region(4096);
      add_random(300);
      drain_all();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_region(65536);
      add_random(300);
      drain_all();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
